[rtl/hvt_pkg.sv]
// Shared types and constants for the homogeneous vertex transform.
`timescale 1ns / 1ps
package hvt_pkg;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 64;
  localparam int NUM_REGS = 8;
  localparam int IDX_W   = 4;
  localparam int SUM_W   = 66;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef logic signed [DATA_W-1:0] word_t;

  // Side data that travels beside the dividers.
  typedef struct packed {
    logic       valid;
    logic       op;
    logic       wz;
    logic [2:0] neg;
    word_t      tx;
    word_t      ty;
    word_t      tz;
    word_t      tw;
  } side_t;
endpackage

[rtl/hvt_mac.sv]
// Matrix-vector multiply: product stage, then sum, floor shift and saturation stage.
`timescale 1ns / 1ps
module hvt_mac import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_op,
  input  word_t vin [4],
  input  word_t coef [4][4],
  output logic  out_valid,
  output logic  out_op,
  output word_t t [4]
);
  localparam logic signed [SUM_W-1:0] MAX66 = SUM_W'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] MIN66 = SUM_W'(SAT_MIN);

  logic signed [2*DATA_W-1:0] prod [4][4];
  logic valid1;
  logic op1;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod[r][c] <= coef[r][c] * vin[c];
      end
    end
    op1 <= in_op;
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
  end

  logic signed [SUM_W-1:0] sum [4];
  logic signed [SUM_W-1:0] sh [4];
  word_t sat [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
             + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
      sh[r] = sum[r] >>> FRAC_BITS;
      if (sh[r] > MAX66) begin
        sat[r] = SAT_MAX;
      end else if (sh[r] < MIN66) begin
        sat[r] = SAT_MIN;
      end else begin
        sat[r] = sh[r][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      t[r] <= sat[r];
    end
    out_op <= op1;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
  end
endmodule

[rtl/hvt_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module hvt_div import hvt_pkg::*; #(
  parameter int NW = 48
) (
  input  logic              clk,
  input  logic [NW-1:0]     num,
  input  logic [DATA_W-1:0] den,
  output logic [NW-1:0]     quo
);
  logic [DATA_W-1:0] rem [NW+1];
  logic [NW-1:0]     nq  [NW+1];
  logic [DATA_W-1:0] dd  [NW+1];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dd[0]  = den;

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DATA_W:0] tr;
    logic [DATA_W:0] nr;
    logic            ge;
    always_comb begin
      tr = {rem[k], nq[k][NW-1]};
      ge = tr >= {1'b0, dd[k]};
      nr = ge ? tr - {1'b0, dd[k]} : tr;
    end
    always_ff @(posedge clk) begin
      rem[k+1] <= nr[DATA_W-1:0];
      nq[k+1]  <= {nq[k][NW-2:0], ge};
      dd[k+1]  <= dd[k];
    end
  end

  assign quo = nq[NW];
endmodule

[rtl/homogeneous_vertex_transform.sv]
// Top level of the homogeneous vertex transform with perspective divide.
`timescale 1ns / 1ps
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  ------------------------------
//  config    cfg_wr, cfg_addr, cfg_data              write when cfg_wr is high
//  item in   op, in_x, in_y, in_z, in_w              taken when start && !busy
//  item out  out_x, out_y, out_z, out_w, w_zero      shown for one cycle with done
//
// The block accepts one item every cycle; busy is always low. Each item passes
// through two multiply and accumulate stages, one sign preparation stage, one
// divider stage per quotient bit, and the output register. The divider depth
// sets the latency. Reset is synchronous and loads the identity matrix and
// clears all valid bits. The receiver cannot stall, and nothing inside ever
// stalls.
module homogeneous_vertex_transform import hvt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [IDX_W-1:0]  cfg_addr,
  input  logic [REG_W-1:0]  cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  output logic              done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic              w_zero
);
  localparam int MW = DATA_W + FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = ONE_LO << DATA_W;

  assign busy = 1'b0;

  // Coefficient registers; the reset value is the identity matrix.
  logic [REG_W-1:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= (i inside {0, 5}) ? ONE_LO : ((i inside {2, 7}) ? ONE_HI : '0);
      end
    end else if (cfg_wr && (cfg_addr < IDX_W'(NUM_REGS))) begin
      regs[cfg_addr[2:0]] <= cfg_data;
    end
  end

  word_t coef [4][4];
  word_t vin [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      coef[r][0] = regs[2*r][DATA_W-1:0];
      coef[r][1] = regs[2*r][REG_W-1:DATA_W];
      coef[r][2] = regs[2*r+1][DATA_W-1:0];
      coef[r][3] = regs[2*r+1][REG_W-1:DATA_W];
    end
    vin[0] = in_x;
    vin[1] = in_y;
    vin[2] = in_z;
    vin[3] = in_w;
  end

  logic  mac_valid;
  logic  mac_op;
  word_t t [4];

  hvt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_op    (op),
    .vin      (vin),
    .coef     (coef),
    .out_valid(mac_valid),
    .out_op   (mac_op),
    .t        (t)
  );

  // Preparation stage: magnitudes of the scaled dividends and of w, and the
  // sign each quotient will take.
  side_t             side [MW+1];
  logic [MW-1:0]     num [3];
  logic [DATA_W-1:0] den;
  logic [DATA_W-1:0] mag [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = t[i][DATA_W-1] ? DATA_W'(-t[i]) : DATA_W'(t[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num[i] <= {mag[i], {FRAC_BITS{1'b0}}};
      side[0].neg[i] <= t[i][DATA_W-1] ^ t[3][DATA_W-1];
    end
    den           <= mag[3];
    side[0].op    <= mac_op;
    side[0].wz    <= mac_op && (t[3] == '0);
    side[0].tx    <= t[0];
    side[0].ty    <= t[1];
    side[0].tz    <= t[2];
    side[0].tw    <= t[3];
    if (rst) begin
      side[0].valid <= 1'b0;
    end else begin
      side[0].valid <= mac_valid;
    end
  end

  logic [MW-1:0] quo [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    hvt_div #(.NW(MW)) u_div (
      .clk(clk),
      .num(num[l]),
      .den(den),
      .quo(quo[l])
    );
  end

  // Side data is delayed to line up with the divider outputs.
  for (genvar k = 0; k < MW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[k+1].valid <= 1'b0;
      end else begin
        side[k+1] <= side[k];
      end
    end
  end

  // Sign restore and saturation of the quotients, then mode selection.
  side_t sd;
  word_t dq [3];
  word_t res [3];
  word_t tv [3];

  always_comb begin
    sd = side[MW];
    tv[0] = sd.tx;
    tv[1] = sd.ty;
    tv[2] = sd.tz;
    for (int i = 0; i < 3; i++) begin
      if (!sd.neg[i]) begin
        dq[i] = (|quo[i][MW-1:DATA_W-1]) ? SAT_MAX : quo[i][DATA_W-1:0];
      end else if ((|quo[i][MW-1:DATA_W]) ||
                   (quo[i][DATA_W-1] && (|quo[i][DATA_W-2:0]))) begin
        dq[i] = SAT_MIN;
      end else begin
        dq[i] = -quo[i][DATA_W-1:0];
      end
      if (!sd.op) begin
        res[i] = tv[i];
      end else if (sd.wz) begin
        res[i] = SAT_MAX;
      end else begin
        res[i] = dq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_x  <= res[0];
    out_y  <= res[1];
    out_z  <= res[2];
    out_w  <= sd.tw;
    w_zero <= sd.wz;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd.valid;
    end
  end
endmodule
